// File: hw/rtl/topt_pkg.sv
// Shared types and codes of the trigger overlap pair table.
package topt_pkg;

  // Operation codes carried in the kind field
  localparam logic [2:0] KIND_ADD       = 3'd0;
  localparam logic [2:0] KIND_DECREASE  = 3'd1;
  localparam logic [2:0] KIND_REMOVE    = 3'd2;
  localparam logic [2:0] KIND_RESET_CNT = 3'd3;
  localparam logic [2:0] KIND_PRUNE     = 3'd4;

  // Result codes carried in the event_res field
  localparam logic [2:0] EV_ENTER      = 3'd0;
  localparam logic [2:0] EV_EXIT       = 3'd1;
  localparam logic [2:0] EV_DONE_OK    = 3'd2;
  localparam logic [2:0] EV_LIST_FULL  = 3'd3;
  localparam logic [2:0] EV_TABLE_FULL = 3'd4;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 3;
  localparam logic [CFG_IW-1:0] CFG_ENTER_ON = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_EXIT_ON  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CAPACITY = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] id_a;
    logic [63:0] id_b;
    logic [31:0] tag_a;
    logic [31:0] tag_b;
    logic [15:0] group_a;
    logic [15:0] group_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] out_tag_a;
    logic [31:0] out_tag_b;
    logic [15:0] out_group_a;
    logic [15:0] out_group_b;
    logic        last;
  } out_item_t;

  // Tag and group of one table entry as stored together
  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] group;
  } obj_info_t;

endpackage

// File: hw/rtl/topt_ram.sv
// Generic single write port RAM with registered read.
module topt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/trigger_overlap_pair_table_core.sv
// Top level of the trigger overlap pair table: sequencer, state and output register.
//
// Usage: one operation per input item (add pair, decrease counts, remove
// object, reset counts, prune) on the in channel; results leave on the out
// channel, zero or more enter/exit events followed by one status item with
// last set. Both channels use valid/stall; an item moves when valid is high
// and stall is low. in_stall_o is high from acceptance until the status
// item has been loaded into the output register.
// A small sequencer walks the object table through one id memory read
// port, one entry at a time, so every lookup scans all OBJECTS entries.
// Each partner list step uses the shared list memory port.
// Configuration must be written on cfg_we_i only while the block is idle; the block does not enforce it.
// Reset empties the table (all entries invalid, all lists empty), enables
// both event kinds and sets the capacity to four. No clearing pass is run.
// A stall on the out channel holds the result in the output register and
// freezes the sequencer at its next result.
module trigger_overlap_pair_table_core
  import topt_pkg::*;
#(
  parameter int OBJECTS = 16,
  parameter int SLOTS   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam int IW     = $clog2(OBJECTS);
  localparam int LW     = $clog2(SLOTS + 1);
  localparam int PDEPTH = OBJECTS * SLOTS;
  localparam int PW     = $clog2(PDEPTH);
  localparam int MAXRES = (OBJECTS * SLOTS) / 2 + 1;
  localparam int EW     = $clog2(MAXRES + 1);
  localparam logic [IW-1:0] LAST_S = IW'(OBJECTS - 1);

  typedef enum logic [30:0] {
    S_IDLE     = 31'(1) << 0,
    S_FIND_RD  = 31'(1) << 1,
    S_FIND_CK  = 31'(1) << 2,
    S_FIND_END = 31'(1) << 3,
    S_LA_RD    = 31'(1) << 4,
    S_LA_CK    = 31'(1) << 5,
    S_LD_RD    = 31'(1) << 6,
    S_LD_CK    = 31'(1) << 7,
    S_LD_MV    = 31'(1) << 8,
    S_ADD_B    = 31'(1) << 9,
    S_ADD_B2   = 31'(1) << 10,
    S_ADD_CA   = 31'(1) << 11,
    S_ADD_CB   = 31'(1) << 12,
    S_ADD_EV   = 31'(1) << 13,
    S_STATUS   = 31'(1) << 14,
    S_DEC_RD   = 31'(1) << 15,
    S_DEC_CK   = 31'(1) << 16,
    S_RM_SLOT  = 31'(1) << 17,
    S_RM_NEXT  = 31'(1) << 18,
    S_RC_SLOT  = 31'(1) << 19,
    S_RC_WR    = 31'(1) << 20,
    S_RC_NEXT  = 31'(1) << 21,
    S_PR_SLOT  = 31'(1) << 22,
    S_PR_RD    = 31'(1) << 23,
    S_PR_CK    = 31'(1) << 24,
    S_PR_INFO  = 31'(1) << 25,
    S_PR_INFOP = 31'(1) << 26,
    S_PR_EV    = 31'(1) << 27,
    S_PR_LAST  = 31'(1) << 28,
    S_PR_MV    = 31'(1) << 29,
    S_PR_NEXT  = 31'(1) << 30
  } state_e;

  // List memory address of entry i of slot s
  function automatic logic [PW-1:0] pa(input logic [IW-1:0] s, input logic [LW-1:0] i);
    return PW'(s) * PW'(SLOTS) + PW'(i);
  endfunction

  // Control state
  state_e state_q, state_d, ret_q, ret_d;
  logic [OBJECTS-1:0] vld_q;
  logic [LW-1:0] pc_q [OBJECTS];
  logic enter_on_q, exit_on_q;
  logic [CFG_DW-1:0] cap_q;
  logic out_vld_q;

  // Item and work registers
  in_item_t item_q;
  logic [IW-1:0] s_q, s_d, sa_q, sa_d, sb_q, sb_d, fa_q, fa_d, fb_q, fb_d;
  logic [IW-1:0] na_q, na_d, nb_q, nb_d, ls_q, ls_d, lp_q, lp_d, p_q, p_d;
  logic sa_f_q, sa_f_d, sb_f_q, sb_f_d, fa_f_q, fa_f_d, fb_f_q, fb_f_d;
  logic found_q, found_d, ok_q, ok_d;
  logic [LW-1:0] i_q, i_d, j_q, j_d;
  logic [2:0] status_q, status_d;
  logic [EW-1:0] ev_cnt_q, ev_cnt_d;
  obj_info_t is_q, is_d;
  out_item_t out_q;

  // Memory ports
  logic id_we, inf_we, pl_we, cn_we;
  logic [IW-1:0] id_wa, inf_wa, inf_ra;
  logic [63:0] id_wd, id_rd;
  obj_info_t inf_wd, inf_rd;
  logic [PW-1:0] pl_wa, pl_ra;
  logic [IW-1:0] pl_wd, pl_rd;
  logic [15:0] cn_wd, cn_rd;

  // State write ports
  logic pc_we;
  logic [IW-1:0] pc_wi;
  logic [LW-1:0] pc_wv;
  logic v_we, v_wv;
  logic [IW-1:0] v_wi;

  logic emit;
  out_item_t emit_item;
  logic out_free, in_acc;
  logic [LW-1:0] pc_ls, pc_s, cap_eff;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;
  assign pc_ls    = pc_q[ls_q];
  assign pc_s     = pc_q[s_q];
  assign cap_eff  = (32'(cap_q) > SLOTS) ? LW'(SLOTS) : LW'(cap_q);

  topt_ram #(.WIDTH(64), .DEPTH(OBJECTS)) u_id_ram (
    .clk_i, .we_i(id_we), .waddr_i(id_wa), .wdata_i(id_wd), .raddr_i(s_q), .rdata_o(id_rd)
  );
  topt_ram #(.WIDTH($bits(obj_info_t)), .DEPTH(OBJECTS)) u_info_ram (
    .clk_i, .we_i(inf_we), .waddr_i(inf_wa), .wdata_i(inf_wd), .raddr_i(inf_ra),
    .rdata_o(inf_rd)
  );
  topt_ram #(.WIDTH(IW), .DEPTH(PDEPTH)) u_partner_ram (
    .clk_i, .we_i(pl_we), .waddr_i(pl_wa), .wdata_i(pl_wd), .raddr_i(pl_ra), .rdata_o(pl_rd)
  );
  topt_ram #(.WIDTH(16), .DEPTH(PDEPTH)) u_count_ram (
    .clk_i, .we_i(cn_we), .waddr_i(pl_wa), .wdata_i(cn_wd), .raddr_i(pl_ra), .rdata_o(cn_rd)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;
    s_d = s_q;  sa_d = sa_q;  sb_d = sb_q;  fa_d = fa_q;  fb_d = fb_q;
    na_d = na_q;  nb_d = nb_q;  ls_d = ls_q;  lp_d = lp_q;  p_d = p_q;
    sa_f_d = sa_f_q;  sb_f_d = sb_f_q;  fa_f_d = fa_f_q;  fb_f_d = fb_f_q;
    found_d = found_q;  ok_d = ok_q;  i_d = i_q;  j_d = j_q;
    status_d = status_q;  ev_cnt_d = ev_cnt_q;  is_d = is_q;
    id_we = 1'b0;  id_wa = na_q;  id_wd = item_q.id_a;
    inf_we = 1'b0;  inf_wa = na_q;  inf_wd = '{tag: item_q.tag_a, group: item_q.group_a};
    inf_ra = s_q;
    pl_we = 1'b0;  cn_we = 1'b0;  pl_wa = pa(ls_q, i_q);  pl_wd = lp_q;  cn_wd = 16'd1;
    pl_ra = pa(ls_q, i_q);
    pc_we = 1'b0;  pc_wi = ls_q;  pc_wv = pc_ls;
    v_we = 1'b0;  v_wi = na_q;  v_wv = 1'b1;
    emit = 1'b0;
    emit_item = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          s_d = '0;
          sa_f_d = 1'b0;  sb_f_d = 1'b0;  fa_f_d = 1'b0;  fb_f_d = 1'b0;
          found_d = 1'b0;  ok_d = 1'b0;  ev_cnt_d = '0;
          status_d = EV_DONE_OK;
          if (in_item_i.kind == KIND_ADD) begin
            state_d = (in_item_i.id_a == in_item_i.id_b) ? S_STATUS : S_FIND_RD;
          end else if (in_item_i.kind == KIND_DECREASE || in_item_i.kind == KIND_REMOVE) begin
            state_d = S_FIND_RD;
          end else if (in_item_i.kind == KIND_RESET_CNT) begin
            state_d = S_RC_SLOT;
          end else if (in_item_i.kind == KIND_PRUNE) begin
            state_d = S_PR_SLOT;
          end else begin
            state_d = S_STATUS;
          end
        end
      end

      // Scan the table for both ids and the first two free slots
      S_FIND_RD: state_d = S_FIND_CK;
      S_FIND_CK: begin
        if (vld_q[s_q]) begin
          if (id_rd == item_q.id_a) begin
            sa_f_d = 1'b1;  sa_d = s_q;
          end
          if (id_rd == item_q.id_b) begin
            sb_f_d = 1'b1;  sb_d = s_q;
          end
        end else if (!fa_f_q) begin
          fa_f_d = 1'b1;  fa_d = s_q;
        end else if (!fb_f_q) begin
          fb_f_d = 1'b1;  fb_d = s_q;
        end
        if (s_q == LAST_S) begin
          state_d = S_FIND_END;
        end else begin
          s_d = s_q + IW'(1);
          state_d = S_FIND_RD;
        end
      end
      S_FIND_END: begin
        if (item_q.kind == KIND_ADD) begin
          na_d = sa_f_q ? sa_q : fa_q;
          nb_d = sb_f_q ? sb_q : (sa_f_q ? fa_q : fb_q);
          if (!(sa_f_q || fa_f_q) || !(sb_f_q || (sa_f_q ? fa_f_q : fb_f_q))) begin
            status_d = EV_TABLE_FULL;
            state_d = S_STATUS;
          end else if (sa_f_q) begin
            ls_d = sa_q;  lp_d = nb_d;  i_d = '0;  ret_d = S_ADD_B;
            state_d = S_LA_RD;
          end else begin
            state_d = S_ADD_B;
          end
        end else if (!sa_f_q) begin
          state_d = S_STATUS;
        end else if (item_q.kind == KIND_DECREASE) begin
          ls_d = sa_q;  i_d = '0;
          state_d = S_DEC_RD;
        end else begin
          s_d = '0;
          state_d = S_RM_SLOT;
        end
      end

      // Add partner lp to the list of ls, or raise its count if it is already there
      S_LA_RD: begin
        if (i_q < pc_ls) begin
          state_d = S_LA_CK;
        end else begin
          found_d = 1'b0;
          if (pc_ls >= cap_eff) begin
            ok_d = 1'b0;
          end else begin
            ok_d = 1'b1;
            pl_we = 1'b1;  cn_we = 1'b1;  pl_wa = pa(ls_q, pc_ls);
            pc_we = 1'b1;  pc_wv = pc_ls + LW'(1);
          end
          state_d = ret_q;
        end
      end
      S_LA_CK: begin
        if (pl_rd == lp_q) begin
          cn_we = 1'b1;
          cn_wd = (cn_rd == 16'hFFFF) ? cn_rd : cn_rd + 16'd1;
          found_d = 1'b1;  ok_d = 1'b1;
          state_d = ret_q;
        end else begin
          i_d = i_q + LW'(1);
          state_d = S_LA_RD;
        end
      end

      // Drop partner lp from the list of ls, moving the last entry into its place
      S_LD_RD: begin
        state_d = (i_q < pc_ls) ? S_LD_CK : ret_q;
      end
      S_LD_CK: begin
        if (pl_rd == lp_q) begin
          pl_ra = pa(ls_q, pc_ls - LW'(1));
          state_d = S_LD_MV;
        end else begin
          i_d = i_q + LW'(1);
          state_d = S_LD_RD;
        end
      end
      S_LD_MV: begin
        pl_we = 1'b1;  cn_we = 1'b1;  pl_wd = pl_rd;  cn_wd = cn_rd;
        pc_we = 1'b1;  pc_wv = pc_ls - LW'(1);
        state_d = ret_q;
      end

      // Add pair: second side, undo on a full list, then create missing sides
      S_ADD_B: begin
        if (sa_f_q && !ok_q) begin
          status_d = EV_LIST_FULL;
          state_d = S_STATUS;
        end else if (sb_f_q) begin
          ls_d = sb_q;  lp_d = na_q;  i_d = '0;  ret_d = S_ADD_B2;
          state_d = S_LA_RD;
        end else begin
          state_d = S_ADD_CA;
        end
      end
      S_ADD_B2: begin
        if (!ok_q) begin
          status_d = EV_LIST_FULL;
          if (sa_f_q) begin
            ls_d = sa_q;  lp_d = nb_q;  i_d = '0;  ret_d = S_STATUS;
            state_d = S_LD_RD;
          end else begin
            state_d = S_STATUS;
          end
        end else begin
          state_d = S_ADD_CA;
        end
      end
      S_ADD_CA: begin
        if (!sa_f_q) begin
          id_we = 1'b1;  inf_we = 1'b1;  v_we = 1'b1;
          pl_wa = pa(na_q, '0);  pl_wd = nb_q;
          pl_we = (cap_eff != '0);  cn_we = (cap_eff != '0);
          pc_we = 1'b1;  pc_wi = na_q;  pc_wv = (cap_eff != '0) ? LW'(1) : '0;
        end
        state_d = S_ADD_CB;
      end
      S_ADD_CB: begin
        if (!sb_f_q) begin
          id_we = 1'b1;  id_wa = nb_q;  id_wd = item_q.id_b;
          inf_we = 1'b1;  inf_wa = nb_q;
          inf_wd = '{tag: item_q.tag_b, group: item_q.group_b};
          v_we = 1'b1;  v_wi = nb_q;
          pl_wa = pa(nb_q, '0);  pl_wd = na_q;
          pl_we = (cap_eff != '0);  cn_we = (cap_eff != '0);
          pc_we = 1'b1;  pc_wi = nb_q;  pc_wv = (cap_eff != '0) ? LW'(1) : '0;
        end
        state_d = S_ADD_EV;
      end
      S_ADD_EV: begin
        if (!found_q && enter_on_q) begin
          if (out_free) begin
            emit = 1'b1;
            emit_item = '{event_res: EV_ENTER, out_tag_a: item_q.tag_a,
                          out_tag_b: item_q.tag_b, out_group_a: item_q.group_a,
                          out_group_b: item_q.group_b, last: 1'b0};
            state_d = S_STATUS;
          end
        end else begin
          state_d = S_STATUS;
        end
      end

      // Final status item
      S_STATUS: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item = '{event_res: status_q, out_tag_a: '0, out_tag_b: '0,
                        out_group_a: '0, out_group_b: '0, last: 1'b1};
          state_d = S_IDLE;
        end
      end

      // Decrease counts of one object, holding at zero
      S_DEC_RD: state_d = (i_q < pc_ls) ? S_DEC_CK : S_STATUS;
      S_DEC_CK: begin
        cn_we = (cn_rd != 16'd0);
        cn_wd = cn_rd - 16'd1;
        i_d = i_q + LW'(1);
        state_d = S_DEC_RD;
      end

      // Remove: drop back references everywhere, then free the entry
      S_RM_SLOT: begin
        if (vld_q[s_q] && s_q != sa_q) begin
          ls_d = s_q;  lp_d = sa_q;  i_d = '0;  ret_d = S_RM_NEXT;
          state_d = S_LD_RD;
        end else begin
          state_d = S_RM_NEXT;
        end
      end
      S_RM_NEXT: begin
        if (s_q == LAST_S) begin
          v_we = 1'b1;  v_wi = sa_q;  v_wv = 1'b0;
          pc_we = 1'b1;  pc_wi = sa_q;  pc_wv = '0;
          state_d = S_STATUS;
        end else begin
          s_d = s_q + IW'(1);
          state_d = S_RM_SLOT;
        end
      end

      // Reset all counts of valid entries
      S_RC_SLOT: begin
        ls_d = s_q;  i_d = '0;
        state_d = vld_q[s_q] ? S_RC_WR : S_RC_NEXT;
      end
      S_RC_WR: begin
        if (i_q < pc_ls) begin
          cn_we = 1'b1;  cn_wd = 16'd0;
          i_d = i_q + LW'(1);
        end else begin
          state_d = S_RC_NEXT;
        end
      end
      S_RC_NEXT: begin
        if (s_q == LAST_S) begin
          state_d = S_STATUS;
        end else begin
          s_d = s_q + IW'(1);
          state_d = S_RC_SLOT;
        end
      end

      // Prune pairs with a zero count, slot by slot
      S_PR_SLOT: begin
        j_d = '0;
        state_d = vld_q[s_q] ? S_PR_RD : S_PR_NEXT;
      end
      S_PR_RD: begin
        pl_ra = pa(s_q, j_q);
        state_d = (j_q < pc_s) ? S_PR_CK : S_PR_NEXT;
      end
      S_PR_CK: begin
        if (cn_rd == 16'd0) begin
          p_d = pl_rd;
          state_d = S_PR_INFO;
        end else begin
          j_d = j_q + LW'(1);
          state_d = S_PR_RD;
        end
      end
      S_PR_INFO: begin
        inf_ra = p_q;
        is_d = inf_rd;
        state_d = S_PR_INFOP;
      end
      S_PR_INFOP: begin
        inf_ra = p_q;
        state_d = S_PR_EV;
      end
      S_PR_EV: begin
        inf_ra = p_q;
        if (exit_on_q && ev_cnt_q < EW'(MAXRES - 1)) begin
          if (out_free) begin
            emit = 1'b1;
            emit_item = '{event_res: EV_EXIT, out_tag_a: is_q.tag, out_tag_b: inf_rd.tag,
                          out_group_a: is_q.group, out_group_b: inf_rd.group, last: 1'b0};
            ev_cnt_d = ev_cnt_q + EW'(1);
            ls_d = p_q;  lp_d = s_q;  i_d = '0;  ret_d = S_PR_LAST;
            state_d = S_LD_RD;
          end
        end else begin
          ls_d = p_q;  lp_d = s_q;  i_d = '0;  ret_d = S_PR_LAST;
          state_d = S_LD_RD;
        end
      end
      S_PR_LAST: begin
        pl_ra = pa(s_q, pc_s - LW'(1));
        state_d = S_PR_MV;
      end
      S_PR_MV: begin
        pl_we = 1'b1;  cn_we = 1'b1;  pl_wa = pa(s_q, j_q);  pl_wd = pl_rd;  cn_wd = cn_rd;
        pc_we = 1'b1;  pc_wi = s_q;  pc_wv = pc_s - LW'(1);
        state_d = S_PR_RD;
      end
      S_PR_NEXT: begin
        if (s_q == LAST_S) begin
          state_d = S_STATUS;
        end else begin
          s_d = s_q + IW'(1);
          state_d = S_PR_SLOT;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      vld_q      <= '0;
      pc_q       <= '{default: '0};
      enter_on_q <= 1'b1;
      exit_on_q  <= 1'b1;
      cap_q      <= CFG_DW'(4);
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (v_we) begin
        vld_q[v_wi] <= v_wv;
      end
      if (pc_we) begin
        pc_q[pc_wi] <= pc_wv;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ENTER_ON: enter_on_q <= cfg_data_i[0];
          CFG_EXIT_ON:  exit_on_q  <= cfg_data_i[0];
          CFG_CAPACITY: cap_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Work and payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    if (emit) begin
      out_q <= emit_item;
    end
    s_q <= s_d;  sa_q <= sa_d;  sb_q <= sb_d;  fa_q <= fa_d;  fb_q <= fb_d;
    na_q <= na_d;  nb_q <= nb_d;  ls_q <= ls_d;  lp_q <= lp_d;  p_q <= p_d;
    sa_f_q <= sa_f_d;  sb_f_q <= sb_f_d;  fa_f_q <= fa_f_d;  fb_f_q <= fb_f_d;
    found_q <= found_d;  ok_q <= ok_d;  i_q <= i_d;  j_q <= j_d;
    status_q <= status_d;  ev_cnt_q <= ev_cnt_d;  is_q <= is_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
